>>> sv/jse_pkg.sv
package jse_pkg;

  // Longest body that a single character can produce (\u00xx escape)
  localparam int unsigned BODY_MAX = 6;

  // ASCII bytes used in the quoted text
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_END = 8'h80;

  // U+FFFD in UTF-8
  localparam logic [7:0] REP_B0 = 8'hef;
  localparam logic [7:0] REP_B1 = 8'hbf;
  localparam logic [7:0] REP_B2 = 8'hbd;

  // UTF-8 lead and continuation ranges
  localparam logic [7:0] LEAD2_LO  = 8'hc2;
  localparam logic [7:0] LEAD2_HI  = 8'hdf;
  localparam logic [7:0] LEAD3_LO  = 8'he0;
  localparam logic [7:0] LEAD3_HI  = 8'hef;
  localparam logic [7:0] LEAD4_LO  = 8'hf0;
  localparam logic [7:0] LEAD4_HI  = 8'hf4;
  localparam logic [7:0] LEAD_SURR = 8'hed;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hbf;
  localparam logic [7:0] E0_MIN    = 8'ha0;
  localparam logic [7:0] ED_MAX    = 8'h9f;
  localparam logic [7:0] F0_MIN    = 8'h90;
  localparam logic [7:0] F4_MAX    = 8'h8f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_string;
    logic       last_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
  } out_beat_t;

  // One classified input byte: the run it releases, in emission order
  typedef struct packed {
    logic                         open_quote;
    logic [1:0]                   pre_reps;
    logic [2:0]                   body_len;
    logic [BODY_MAX-1:0][7:0]     body;
    logic [1:0]                   post_reps;
    logic                         close_quote;
  } cmd_t;

endpackage

>>> sv/jse_stream_if.sv
interface jse_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/jse_front.sv
module jse_front import jse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  jse_stream_if.sink   in_i,
  jse_stream_if.source cmd_o
);

  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] exp_q, exp_d;

  logic [7:0] c;
  logic       first, last;
  logic [1:0] cnt_e;
  logic [2:0] exp_e;
  logic       cont;
  logic       nonempty;
  logic       acc;
  cmd_t       cmd;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = CH_ZERO + {4'd0, v};
    else r = 8'h57 + {4'd0, v};
    return r;
  endfunction

  always_comb begin
    c     = in_i.data.data_byte;
    first = in_i.data.first_of_string;
    last  = in_i.data.last_of_string;
    // a new string drops whatever the previous one left buffered
    cnt_e = first ? 2'd0 : cnt_q;
    exp_e = first ? 3'd0 : exp_q;

    cont = (c >= CONT_LO) && (c <= CONT_HI);
    if (cnt_e == 2'd1) begin
      if ((pend_q[0] == LEAD3_LO  && c < E0_MIN) ||
          (pend_q[0] == LEAD_SURR && c > ED_MAX) ||
          (pend_q[0] == LEAD4_LO  && c < F0_MIN) ||
          (pend_q[0] == LEAD4_HI  && c > F4_MAX)) begin
        cont = 1'b0;
      end
    end

    cmd            = '0;
    pend_d         = pend_q;
    cnt_d          = cnt_e;
    exp_d          = exp_e;
    cmd.open_quote = first;

    if (cnt_e == 2'd0 || !cont) begin
      // nothing buffered or broken sequence: one replacement per buffered byte, then restart
      cmd.pre_reps = cnt_e;
      cnt_d        = 2'd0;
      exp_d        = 3'd0;
      if (c < ASCII_END) begin
        unique case (c)
          CH_QUOTE: begin
            cmd.body[0] = CH_BSLASH; cmd.body[1] = CH_QUOTE; cmd.body_len = 3'd2;
          end
          CH_BSLASH: begin
            cmd.body[0] = CH_BSLASH; cmd.body[1] = CH_BSLASH; cmd.body_len = 3'd2;
          end
          CH_LF: begin
            cmd.body[0] = CH_BSLASH; cmd.body[1] = CH_N; cmd.body_len = 3'd2;
          end
          CH_CR: begin
            cmd.body[0] = CH_BSLASH; cmd.body[1] = CH_R; cmd.body_len = 3'd2;
          end
          CH_TAB: begin
            cmd.body[0] = CH_BSLASH; cmd.body[1] = CH_T; cmd.body_len = 3'd2;
          end
          default: begin
            if (c < CH_SPACE || c == CH_DEL) begin
              cmd.body[0]  = CH_BSLASH;
              cmd.body[1]  = CH_U;
              cmd.body[2]  = CH_ZERO;
              cmd.body[3]  = CH_ZERO;
              cmd.body[4]  = hex_digit(c[7:4]);
              cmd.body[5]  = hex_digit(c[3:0]);
              cmd.body_len = 3'd6;
            end else begin
              cmd.body[0]  = c;
              cmd.body_len = 3'd1;
            end
          end
        endcase
      end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
        pend_d[0] = c; cnt_d = 2'd1; exp_d = 3'd2;
      end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
        pend_d[0] = c; cnt_d = 2'd1; exp_d = 3'd3;
      end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
        pend_d[0] = c; cnt_d = 2'd1; exp_d = 3'd4;
      end else begin
        cmd.body[0]  = REP_B0;
        cmd.body[1]  = REP_B1;
        cmd.body[2]  = REP_B2;
        cmd.body_len = 3'd3;
      end
    end else if (({1'b0, cnt_e} + 3'd1) >= exp_e) begin
      // sequence complete: pass buffered bytes plus this one
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt_e) cmd.body[i] = pend_q[i];
      end
      cmd.body[{1'b0, cnt_e}] = c;
      cmd.body_len            = {1'b0, cnt_e} + 3'd1;
      cnt_d                   = 2'd0;
      exp_d                   = 3'd0;
    end else begin
      pend_d[cnt_e] = c;
      cnt_d         = cnt_e + 2'd1;
    end

    if (last) begin
      cmd.post_reps   = cnt_d;
      cmd.close_quote = 1'b1;
      cnt_d           = 2'd0;
      exp_d           = 3'd0;
    end

    nonempty = cmd.open_quote || (cmd.pre_reps != 2'd0) || (cmd.body_len != 3'd0) ||
               (cmd.post_reps != 2'd0) || cmd.close_quote;
  end

  // a byte that is only buffered is taken without a queue entry
  assign in_i.ready  = cmd_o.ready;
  assign cmd_o.valid = in_i.valid && nonempty;
  assign cmd_o.data  = cmd;
  assign acc         = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      exp_q <= 3'd0;
    end else if (acc) begin
      cnt_q <= cnt_d;
      exp_q <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_q <= pend_d;
    end
  end

endmodule

>>> sv/jse_queue.sv
module jse_queue import jse_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jse_stream_if.sink   push_i,
  jse_stream_if.source pop_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_i.ready = (cnt_q != CntW'(Depth));
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.data   = mem_q[rd_q];
  assign do_push      = push_i.valid && push_i.ready;
  assign do_pop       = pop_o.valid && pop_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.data;
  end

endmodule

>>> sv/jse_back.sv
module jse_back import jse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  jse_stream_if.sink   cmd_i,
  jse_stream_if.source out_o
);

  typedef enum logic [2:0] {
    PH_OPEN  = 3'd0,
    PH_PRE   = 3'd1,
    PH_BODY  = 3'd2,
    PH_POST  = 3'd3,
    PH_CLOSE = 3'd4
  } phase_e;

  localparam int unsigned NumPh = 5;

  phase_e     ph_q, ph_cur, first_ph, nxt_ph;
  logic       fresh_q;
  logic [1:0] rep_q;
  logic [2:0] sub_q;
  logic       out_valid_q;
  out_beat_t  out_q;

  cmd_t             cmd;
  logic [NumPh-1:0] has;
  logic             first_found, nxt_found;
  logic             adv, ph_end;
  logic [7:0]       cur_byte;

  function automatic logic [7:0] rep_byte(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = REP_B0;
      2'd1:    r = REP_B1;
      default: r = REP_B2;
    endcase
    return r;
  endfunction

  always_comb begin
    cmd           = cmd_i.data;
    has[PH_OPEN]  = cmd.open_quote;
    has[PH_PRE]   = (cmd.pre_reps != 2'd0);
    has[PH_BODY]  = (cmd.body_len != 3'd0);
    has[PH_POST]  = (cmd.post_reps != 2'd0);
    has[PH_CLOSE] = cmd.close_quote;

    first_found = 1'b0;
    first_ph    = PH_OPEN;
    for (int k = 0; k < NumPh; k++) begin
      if (!first_found && has[k]) begin
        first_found = 1'b1;
        first_ph    = phase_e'(3'(k));
      end
    end
    ph_cur = fresh_q ? first_ph : ph_q;

    nxt_found = 1'b0;
    nxt_ph    = PH_CLOSE;
    for (int k = 0; k < NumPh; k++) begin
      if (!nxt_found && has[k] && (3'(k) > ph_cur)) begin
        nxt_found = 1'b1;
        nxt_ph    = phase_e'(3'(k));
      end
    end

    unique case (ph_cur)
      PH_OPEN, PH_CLOSE: begin
        cur_byte = CH_QUOTE;
        ph_end   = 1'b1;
      end
      PH_PRE: begin
        cur_byte = rep_byte(sub_q[1:0]);
        ph_end   = (sub_q == 3'd2) && (rep_q == 2'(cmd.pre_reps - 2'd1));
      end
      PH_POST: begin
        cur_byte = rep_byte(sub_q[1:0]);
        ph_end   = (sub_q == 3'd2) && (rep_q == 2'(cmd.post_reps - 2'd1));
      end
      PH_BODY: begin
        cur_byte = cmd.body[sub_q];
        ph_end   = (sub_q == 3'(cmd.body_len - 3'd1));
      end
      default: begin
        cur_byte = CH_QUOTE;
        ph_end   = 1'b1;
      end
    endcase
  end

  assign adv         = cmd_i.valid && (!out_valid_q || out_o.ready);
  assign cmd_i.ready = adv && ph_end && !nxt_found;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_OPEN;
      fresh_q     <= 1'b1;
      rep_q       <= 2'd0;
      sub_q       <= 3'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (adv) begin
        out_valid_q       <= 1'b1;
        out_q.out_byte    <= cur_byte;
        out_q.last_in_run <= ph_end && !nxt_found;
        if (ph_end) begin
          rep_q <= 2'd0;
          sub_q <= 3'd0;
          if (nxt_found) begin
            ph_q    <= nxt_ph;
            fresh_q <= 1'b0;
          end else begin
            fresh_q <= 1'b1;
          end
        end else begin
          ph_q    <= ph_cur;
          fresh_q <= 1'b0;
          if ((ph_cur == PH_PRE || ph_cur == PH_POST) && sub_q == 3'd2) begin
            sub_q <= 3'd0;
            rep_q <= rep_q + 2'd1;
          end else begin
            sub_q <= sub_q + 3'd1;
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> sv/json_string_escape_utf8_check.sv
// Channel  Dir  Payload                                          Beat
// in_i     in   data_byte[8], first_of_string, last_of_string    one raw string byte
// out_o    out  out_byte[8], last_in_run                         one byte of JSON text
//
// One output beat per cycle while out_o is ready; with one-byte runs, one input byte too.
// A byte that releases N output bytes (up to 16) holds the back end until all are sent;
// the input stalls only once the command queue (QueueDepth entries) is full.
// Bytes that are merely buffered (UTF-8 leads and continuations) take no queue entry.
// Reset clears the UTF-8 tracking state, the queue and the output register.
module json_string_escape_utf8_check import jse_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jse_stream_if.sink   in_i,
  jse_stream_if.source out_o
);

  // front end -> queue, queue -> back end: one classified run per entry
  jse_stream_if #(.T(cmd_t)) fq ();
  jse_stream_if #(.T(cmd_t)) qb ();

  // classifier: escapes, UTF-8 validation, pending byte buffer
  jse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_o  (fq)
  );

  // decouples classification from byte-serial emission
  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq),
    .pop_o  (qb)
  );

  // sequencer: quote, replacements, body, replacements, quote; output register
  jse_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (qb),
    .out_o  (out_o)
  );

endmodule
